@@ sv/gant_pkg.sv @@
// Shared types, codes and turn rule for the grid ant step unit.
package gant_pkg;

    typedef logic [1:0] heading_t;
    typedef logic       opcode_t;

    localparam opcode_t OP_STEP = 1'b0;
    localparam opcode_t OP_READ = 1'b1;

    localparam heading_t HEAD_DOWN  = 2'd0;
    localparam heading_t HEAD_UP    = 2'd1;
    localparam heading_t HEAD_RIGHT = 2'd2;
    localparam heading_t HEAD_LEFT  = 2'd3;

    localparam int FIELD_W = 6;
    localparam int COUNT_W = 32;

    // New heading from current heading and entered color (1 black).
    function automatic heading_t gant_turn(input heading_t cur, input logic black);
        heading_t res;
        case (cur)
            HEAD_DOWN:  res = black ? HEAD_RIGHT : HEAD_LEFT;
            HEAD_UP:    res = black ? HEAD_LEFT  : HEAD_RIGHT;
            HEAD_RIGHT: res = black ? HEAD_UP    : HEAD_DOWN;
            HEAD_LEFT:  res = black ? HEAD_DOWN  : HEAD_UP;
            default:    res = HEAD_DOWN;
        endcase
        return res;
    endfunction

endpackage

@@ sv/grid_ant_automaton_step_unit.sv @@
// Grid ant step unit: one-bit torus grid in a synchronous RAM, ant state in registers.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | into unit | in_valid / in_ready  | opcode, read_row, read_col
//  out     | out       | out_valid / out_ready| ant_row, ant_col, heading, cell_black,
//          |           |                      | step_count
//
// Each item: the grid RAM read issues at acceptance; as the item leaves the read stage,
// a step turns, flips and writes back the cell, and the output register loads. Read
// stage and output register overlap, so one item per cycle is sustained while out_ready
// is high; the new heading is forwarded so a step can issue as its predecessor retires.
// Reset starts a clearing pass over 2**(RW+CW) cells (4096 at 64 x 64), one cell per
// cycle, with in_ready low; a stalled out channel backs up and drops in_ready.
module grid_ant_automaton_step_unit #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  gant_pkg::opcode_t        opcode,
    input  logic [5:0]               read_row,
    input  logic [5:0]               read_col,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [5:0]               ant_row,
    output logic [5:0]               ant_col,
    output gant_pkg::heading_t       heading,
    output logic                     cell_black,
    output logic [31:0]              step_count
);
    import gant_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [AW-1:0] CENTER_ADDR = AW'((ROWS / 2) * (1 << CW) + (COLS / 2));

    // Grid RAM, address is {row, col}
    logic          grid_mem [DEPTH];
    logic          mem_q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // Clearing pass
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // Architectural ant state (position commits at issue, heading at retire)
    logic [RW-1:0]      pos_row_reg, pos_row_next;
    logic [CW-1:0]      pos_col_reg, pos_col_next;
    heading_t           dir_reg, dir_next;
    logic [COUNT_W-1:0] moves_reg, moves_next;

    // Read stage
    logic          s1_valid_reg, s1_valid_next;
    opcode_t       s1_op_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_inrange_reg;
    logic          s1_fwd_reg;
    logic          s1_fwd_val_reg;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] o_row_reg, o_col_reg;
    heading_t           o_head_reg;
    logic               o_black_reg;
    logic [COUNT_W-1:0] o_count_reg;

    logic          issue;
    logic          retire;
    logic          retire_step;
    logic          s1_color;
    heading_t      dir_turn;
    heading_t      eff_dir;
    logic [RW-1:0] mv_row;
    logic [CW-1:0] mv_col;
    logic [15:0]   rd_row_ext, rd_col_ext;
    logic          rd_inrange;
    logic [15:0]   pos_row_ext, pos_col_ext;

    assign retire      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign retire_step = retire && (s1_op_reg == OP_STEP);
    assign in_ready    = !clr_busy_reg && (!s1_valid_reg || retire);
    assign issue       = in_valid && in_ready;

    assign s1_color = s1_fwd_reg ? s1_fwd_val_reg : mem_q_reg;
    assign dir_turn = gant_turn(dir_reg, s1_color);
    assign eff_dir  = retire_step ? dir_turn : dir_reg;

    // Move one cell along the forwarded heading, wrapping on the torus
    always_comb
    begin
        mv_row = pos_row_reg;
        mv_col = pos_col_reg;
        case (eff_dir)
            HEAD_DOWN:  mv_row = (pos_row_reg == RW'(ROWS - 1)) ? '0 : pos_row_reg + 1'b1;
            HEAD_UP:    mv_row = (pos_row_reg == '0) ? RW'(ROWS - 1) : pos_row_reg - 1'b1;
            HEAD_RIGHT: mv_col = (pos_col_reg == CW'(COLS - 1)) ? '0 : pos_col_reg + 1'b1;
            HEAD_LEFT:  mv_col = (pos_col_reg == '0) ? CW'(COLS - 1) : pos_col_reg - 1'b1;
            default:    mv_row = pos_row_reg;
        endcase
    end

    assign rd_row_ext = 16'(read_row);
    assign rd_col_ext = 16'(read_col);
    assign rd_inrange = (rd_row_ext < 16'(ROWS)) && (rd_col_ext < 16'(COLS));

    // RAM port control
    always_comb
    begin
        mem_re    = issue;
        mem_raddr = (opcode == OP_STEP) ? {mv_row, mv_col}
                                        : {rd_row_ext[RW-1:0], rd_col_ext[CW-1:0]};
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = (clr_addr_reg == CENTER_ADDR);
        end
        else
        begin
            mem_we    = retire_step;
            mem_waddr = s1_addr_reg;
            mem_wdata = ~s1_color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q_reg <= grid_mem[mem_raddr];
    end

    // Next state of control and ant registers
    always_comb
    begin
        pos_row_next   = pos_row_reg;
        pos_col_next   = pos_col_reg;
        dir_next       = dir_reg;
        moves_next     = moves_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (retire)
        begin
            out_valid_next = 1'b1;
            s1_valid_next  = 1'b0;
        end
        if (retire_step)
        begin
            dir_next   = dir_turn;
            moves_next = moves_reg + 1'b1;
        end
        if (issue)
        begin
            s1_valid_next = 1'b1;
            if (opcode == OP_STEP)
            begin
                pos_row_next = mv_row;
                pos_col_next = mv_col;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            pos_row_reg   <= RW'(ROWS / 2);
            pos_col_reg   <= CW'(COLS / 2);
            dir_reg       <= HEAD_DOWN;
            moves_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                    clr_busy_reg <= 1'b0;
            end
            pos_row_reg   <= pos_row_next;
            pos_col_reg   <= pos_col_next;
            dir_reg       <= dir_next;
            moves_reg     <= moves_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Read stage payload; forward a write-back that hits the cell being read
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_op_reg      <= opcode;
            s1_addr_reg    <= mem_raddr;
            s1_inrange_reg <= (opcode == OP_STEP) || rd_inrange;
            s1_fwd_reg     <= mem_we && (mem_waddr == mem_raddr);
            s1_fwd_val_reg <= mem_wdata;
        end
    end

    assign pos_row_ext = 16'(pos_row_reg);
    assign pos_col_ext = 16'(pos_col_reg);

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            o_row_reg <= pos_row_ext[FIELD_W-1:0];
            o_col_reg <= pos_col_ext[FIELD_W-1:0];
            if (s1_op_reg == OP_STEP)
            begin
                o_head_reg  <= dir_turn;
                o_black_reg <= ~s1_color;
                o_count_reg <= moves_reg + 1'b1;
            end
            else
            begin
                o_head_reg  <= dir_reg;
                o_black_reg <= s1_color & s1_inrange_reg;
                o_count_reg <= moves_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign ant_row    = o_row_reg;
    assign ant_col    = o_col_reg;
    assign heading    = o_head_reg;
    assign cell_black = o_black_reg;
    assign step_count = o_count_reg;

endmodule

@@ sv/gant_chk.sv @@
// Port-level checker for the grid ant step unit, with its bind.
module gant_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        opcode,
    input logic [5:0]  read_row,
    input logic [5:0]  read_col,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  ant_row,
    input logic [5:0]  ant_col,
    input logic [1:0]  heading,
    input logic        cell_black,
    input logic [31:0] step_count
);

    // Clearing pass blocks input right after reset
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
        else $error("in_ready high during grid clearing pass");

    // A fresh result traces back to an accepted item that passed the read stage
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without matching item two cycles earlier");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ant_row) && $stable(ant_col)
            && $stable(heading) && $stable(cell_black) && $stable(step_count))
        else $error("stalled result changed");

endmodule

bind grid_ant_automaton_step_unit gant_chk u_gant_chk (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the grid ant step unit: predicted results, random traffic and stalls.
module tb_top;
    import gant_pkg::*;

    localparam int ROWS = 64;
    localparam int COLS = 64;
    // Longest stretches with no handshake on either side: the clearing pass after
    // reset and the long receiver hold-off.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 10;

    // One item waiting to be driven. For a relative read, row/col are offsets
    // added to the ant position known when the item goes onto the bus.
    typedef struct {
        opcode_t    op;
        logic [5:0] row;
        logic [5:0] col;
        logic       rel;
    } ant_cmd_t;

    // One expected result.
    typedef struct {
        logic [5:0]  row;
        logic [5:0]  col;
        heading_t    dir;
        logic        black;
        logic [31:0] moves;
    } ant_view_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    opcode_t     opcode    = OP_STEP;
    logic [5:0]  read_row  = '0;
    logic [5:0]  read_col  = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  ant_row;
    logic [5:0]  ant_col;
    heading_t    heading;
    logic        cell_black;
    logic [31:0] step_count;

    ant_cmd_t  pending_cmds[$];
    ant_view_t expected_views[$];

    // Predictor copy of the ant and its world.
    logic        grid_model [0:ROWS*COLS-1];
    int          ant_r;
    int          ant_c;
    heading_t    ant_dir;
    logic [31:0] ant_moves;

    int n_errors      = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    grid_ant_automaton_step_unit #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .read_row   (read_row),
        .read_col   (read_col),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ant_row    (ant_row),
        .ant_col    (ant_col),
        .heading    (heading),
        .cell_black (cell_black),
        .step_count (step_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // White cell: turn right relative to travel; black cell: turn left.
    function automatic heading_t ant_turn(input heading_t cur, input logic black);
        heading_t nxt;
        case ({cur, black})
            {HEAD_DOWN,  1'b0}: nxt = HEAD_LEFT;
            {HEAD_DOWN,  1'b1}: nxt = HEAD_RIGHT;
            {HEAD_UP,    1'b0}: nxt = HEAD_RIGHT;
            {HEAD_UP,    1'b1}: nxt = HEAD_LEFT;
            {HEAD_RIGHT, 1'b0}: nxt = HEAD_DOWN;
            {HEAD_RIGHT, 1'b1}: nxt = HEAD_UP;
            {HEAD_LEFT,  1'b0}: nxt = HEAD_UP;
            default:            nxt = HEAD_DOWN;
        endcase
        return nxt;
    endfunction

    // Apply one accepted item to the model and queue the result it must give.
    task automatic predict_ant_item(input opcode_t op, input logic [5:0] r,
                                    input logic [5:0] c);
        ant_view_t v;
        int        idx;
        logic      color;
        if (op == OP_READ)
        begin
            color = 1'b0;
            if (int'(r) < ROWS && int'(c) < COLS)
                color = grid_model[int'(r) * COLS + int'(c)];
        end
        else
        begin
            // torus: each edge wraps to the opposite one
            case (ant_dir)
                HEAD_DOWN:  ant_r = (ant_r == ROWS - 1) ? 0 : ant_r + 1;
                HEAD_UP:    ant_r = (ant_r == 0) ? ROWS - 1 : ant_r - 1;
                HEAD_RIGHT: ant_c = (ant_c == COLS - 1) ? 0 : ant_c + 1;
                default:    ant_c = (ant_c == 0) ? COLS - 1 : ant_c - 1;
            endcase
            idx       = ant_r * COLS + ant_c;
            color     = grid_model[idx];
            ant_dir   = ant_turn(ant_dir, color);
            color     = ~color;
            grid_model[idx] = color;
            ant_moves = ant_moves + 32'd1;
        end
        v.row   = ant_r[5:0];
        v.col   = ant_c[5:0];
        v.dir   = ant_dir;
        v.black = color;
        v.moves = ant_moves;
        expected_views.push_back(v);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    task automatic push_cmd(input opcode_t op, input logic [5:0] r, input logic [5:0] c,
                            input logic rel);
        ant_cmd_t cmd;
        cmd.op  = op;
        cmd.row = r;
        cmd.col = c;
        cmd.rel = rel;
        pending_cmds.push_back(cmd);
    endtask

    // Mixed traffic. Reads split between cells around the ant (just entered,
    // just left, neighbors) and cells anywhere on the grid.
    task automatic queue_mixed_items(input int n, input int read_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) >= read_pct)
                push_cmd(OP_STEP, 6'($urandom), 6'($urandom), 1'b0);
            else if ($urandom_range(0, 1) == 0)
                push_cmd(OP_READ, 6'($urandom_range(0, 4) - 2),
                         6'($urandom_range(0, 4) - 2), 1'b1);
            else
                push_cmd(OP_READ, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'b0);
        end
    endtask

    // Driver: at each accepting edge the model takes the item first, so a
    // relative read that follows resolves against the updated ant position.
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        ant_cmd_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode   <= OP_STEP;
            read_row <= '0;
            read_col <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_ant_item(opcode, read_row, read_col);
            if (!in_valid || in_ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt      = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    opcode   <= nxt.op;
                    if (nxt.rel)
                    begin
                        read_row <= 6'(ant_r + int'(nxt.row));
                        read_col <= 6'(ant_c + int'(nxt.col));
                    end
                    else
                    begin
                        read_row <= nxt.row;
                        read_col <= nxt.col;
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result against the oldest expectation, then pick
    // next cycle's ready (long hold-off when requested, else random stalls).
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        ant_view_t exp_v;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_views.size() == 0)
                begin
                    $error("result with no item outstanding");
                    n_errors++;
                end
                else
                begin
                    exp_v = expected_views.pop_front();
                    check_field("ant_row", 32'(exp_v.row), 32'(ant_row));
                    check_field("ant_col", 32'(exp_v.col), 32'(ant_col));
                    check_field("heading", 32'(exp_v.dir), 32'(heading));
                    check_field("cell_black", 32'(exp_v.black), 32'(cell_black));
                    check_field("step_count", exp_v.moves, step_count);
                end
            end
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        // model state at reset: clear grid, black start cell, ant centered heading down
        for (int i = 0; i < ROWS * COLS; i++)
            grid_model[i] = 1'b0;
        ant_r     = ROWS / 2;
        ant_c     = COLS / 2;
        ant_dir   = HEAD_DOWN;
        ant_moves = '0;
        grid_model[ant_r * COLS + ant_c] = 1'b1;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase 1: sender idles 30 %, receiver 88 %.
        send_idle_pct = 30;
        recv_idle_pct = 88;

        // Directed: black start cell, grid corners, then steps with reads of
        // the cell just entered (back to back with the write) and just left.
        push_cmd(OP_READ, 6'd32, 6'd32, 1'b0);
        push_cmd(OP_READ, 6'd0,  6'd0,  1'b0);
        push_cmd(OP_READ, 6'd63, 6'd63, 1'b0);
        push_cmd(OP_READ, 6'd0,  6'd63, 1'b0);
        push_cmd(OP_READ, 6'd63, 6'd0,  1'b0);
        push_cmd(OP_STEP, 6'd63, 6'd63, 1'b0);
        push_cmd(OP_READ, 6'd0,  6'd0,  1'b1);
        push_cmd(OP_READ, 6'h3f, 6'd0,  1'b1);
        push_cmd(OP_STEP, 6'd0,  6'd0,  1'b0);
        push_cmd(OP_STEP, 6'h2a, 6'h15, 1'b0);
        push_cmd(OP_READ, 6'd0,  6'd0,  1'b1);
        push_cmd(OP_STEP, 6'd0,  6'd0,  1'b0);
        push_cmd(OP_STEP, 6'd0,  6'd0,  1'b0);
        push_cmd(OP_STEP, 6'd0,  6'd0,  1'b0);
        push_cmd(OP_STEP, 6'd0,  6'd0,  1'b0);
        push_cmd(OP_READ, 6'd1,  6'd0,  1'b1);
        push_cmd(OP_READ, 6'd0,  6'd1,  1'b1);
        push_cmd(OP_READ, 6'd32, 6'd32, 1'b0);
        queue_mixed_items(540, 30);
        while (pending_cmds.size() != 0) @(negedge clk);

        // Phase 2: roles swapped.
        send_idle_pct = 88;
        recv_idle_pct = 30;
        queue_mixed_items(540, 30);
        while (pending_cmds.size() != 0) @(negedge clk);

        // Phase 3: no idling; a long receiver hold-off first so the unit
        // backs up and drops in_ready while items keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs++;
        queue_mixed_items(540, 30);

        while (pending_cmds.size() != 0 || in_valid || expected_views.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
